// File: rtl/twcs_pkg.sv
// twcs_pkg: shared constants, types and helpers for the textured wall column span block
// used by twcs_seq_unit and textured_wall_column_span, no dependencies
package twcs_pkg;

   localparam int SCREEN_HEIGHT = 480;
   localparam int TEXTURE_MAX   = 1024;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

   localparam int TEX_SIZE_W = 11;   // texture size register width
   localparam int TEXEL_W    = 10;   // clamped texel coordinate width
   localparam int HEIGHT_W   = 24;   // wall height, Q16.8
   localparam int FRAC_W     = 16;   // hit fraction, Q0.16
   localparam int ROW_W      = 10;
   localparam int ACC_W      = 34;   // step and accumulator, Q18.16
   localparam int END_W      = 25;   // span end in Q.8
   localparam int NEG_W      = HEIGHT_W - 9;
   localparam int QUO_W      = TEX_SIZE_W + HEIGHT_W;
   localparam int SUM_W      = ACC_W + 2;
   localparam int CNT_W      = 6;
   localparam int DIV_STEPS  = QUO_W;
   localparam int MUL_STEPS  = NEG_W;

   localparam logic [ACC_W-1:0]    ACC_MAX = {ACC_W{1'b1}};
   localparam logic [HEIGHT_W:0]   HALF_Q9 = (HEIGHT_W+1)'(HALF_HEIGHT * 512);
   localparam logic [END_W-1:0]    HALF_Q8 = END_W'(HALF_HEIGHT * 256);
   localparam logic [TEX_SIZE_W-1:0] TEX_MAX_V = TEX_SIZE_W'(TEXTURE_MAX);

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] TEX_EAST  = 2'd0;
   localparam logic [1:0] TEX_WEST  = 2'd1;
   localparam logic [1:0] TEX_SOUTH = 2'd2;
   localparam logic [1:0] TEX_NORTH = 2'd3;

   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   typedef struct packed {
      logic                  start;
      logic [TEX_SIZE_W-1:0] heff;
      logic [HEIGHT_W-1:0]   height;
      logic [NEG_W-1:0]      neg_rows;
   } ureq_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] step;
      logic [ACC_W-1:0] product;
   } ures_type;

   // zero counts as one, oversized as the maximum
   function automatic logic [TEX_SIZE_W-1:0] eff_size(input logic [TEX_SIZE_W-1:0] v);
      logic [TEX_SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = TEX_SIZE_W'(1);
      else if (v > TEX_MAX_V) r = TEX_MAX_V;
      return r;
   endfunction

   function automatic logic [TEXEL_W-1:0] clamp_texel(input logic [17:0] v,
                                                      input logic [TEX_SIZE_W-1:0] size);
      logic [17:0] lim;
      logic [17:0] r;
      lim = {7'd0, size} - 18'd1;
      r = v;
      if (r > lim) r = lim;
      if (r > 18'd1023) r = 18'd1023;
      return r[TEXEL_W-1:0];
   endfunction

endpackage

// File: rtl/textured_wall_column_span.sv
// textured_wall_column_span: top level, stream ports, span state and pixel output register
// depends on twcs_pkg and twcs_seq_unit
//
// A start word (tuser 0) sets up one wall column: after it is accepted, 35 divide
// steps for the texture row step and 15 multiply steps for the rows clipped off
// the screen top run on the one shared adder of twcs_seq_unit; req_tready stays
// low meanwhile. A tick word (tuser 1), while a span is active, puts one pixel
// word in the output register, so ticks run at one pixel per clock when the sink
// keeps rsp_tready high. Ticks with no active span give nothing. The texture size
// registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while idle, as the block itself does not enforce it.
module textured_wall_column_span import twcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // column[9:0], hit_x_fraction[25:10], hit_y_fraction[41:26], hit_side[42],
   // dir_x_positive[43], dir_y_positive[44], wall_height[68:45], zero[71:69]
   input  logic [71:0] req_tdata,
   // opcode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // screen_x[9:0], screen_y[18:10], texture_id[20:19], texel_col[30:21],
   // texel_row[40:31], zero[47:41]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   logic [TEX_SIZE_W-1:0] width_ff;
   logic [TEX_SIZE_W-1:0] height_ff;
   logic                  span_active_ff;
   logic [9:0]            column_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [END_W-1:0]      span_end_ff;
   logic [ACC_W-1:0]      step_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [1:0]            texture_ff;
   logic [TEXEL_W-1:0]    texel_col_ff;
   logic                  out_valid_ff;
   logic [47:0]           out_data_ff;
   logic                  out_last_ff;

   ureq_type ureq;
   ures_type ures;

   logic                  accept;
   logic                  start_acc;
   logic                  tick_acc;
   logic [9:0]            in_column;
   logic [FRAC_W-1:0]     in_hit_x;
   logic [FRAC_W-1:0]     in_hit_y;
   logic                  in_side;
   logic                  in_dir_x;
   logic                  in_dir_y;
   logic [HEIGHT_W-1:0]   in_height;
   logic [HEIGHT_W-1:0]   h_raised;
   logic [TEX_SIZE_W-1:0] weff;
   logic [TEX_SIZE_W-1:0] heff;
   logic [FRAC_W-1:0]     frac;
   logic [FRAC_W+TEX_SIZE_W-1:0] col_prod;
   logic                  above_top;
   logic [HEIGHT_W:0]     top_diff;
   logic [HEIGHT_W:0]     neg_diff;
   logic [ROW_W-1:0]      top_row;
   logic [END_W-1:0]      span_end_in;
   logic [ROW_W-1:0]      next_row;
   logic                  tick_last;
   logic [ACC_W:0]        acc_sum;
   logic [TEXEL_W-1:0]    texel_row;

   function automatic logic in_span(input logic [ROW_W-1:0] row,
                                    input logic [END_W-1:0] span_end);
      logic [END_W-1:0] row_q8;
      row_q8 = {{(END_W-ROW_W-8){1'b0}}, row, 8'd0};
      return ({1'b0, row} < (ROW_W+1)'(SCREEN_HEIGHT)) && (row_q8 < span_end);
   endfunction

   assign in_column = req_tdata[9:0];
   assign in_hit_x  = req_tdata[25:10];
   assign in_hit_y  = req_tdata[41:26];
   assign in_side   = req_tdata[42];
   assign in_dir_x  = req_tdata[43];
   assign in_dir_y  = req_tdata[44];
   assign in_height = req_tdata[68:45];

   assign req_tready = !ures.busy && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign start_acc  = accept && (req_tuser == OP_START);
   assign tick_acc   = accept && (req_tuser == OP_TICK);

   assign weff     = eff_size(width_ff);
   assign heff     = eff_size(height_ff);
   assign h_raised = (in_height == '0) ? HEIGHT_W'(1) : in_height;
   assign frac     = in_side ? in_hit_x : in_hit_y;
   assign col_prod = frac * weff;

   // wall top above the screen: clip and start the accumulator further down
   assign above_top   = ({1'b0, h_raised} > HALF_Q9);
   assign top_diff    = HALF_Q9 - {1'b0, h_raised};
   assign neg_diff    = {1'b0, h_raised} - HALF_Q9;
   assign top_row     = above_top ? '0 : ROW_W'(top_diff >> 9);
   assign span_end_in = HALF_Q8 + END_W'(({1'b0, h_raised} + 25'd1) >> 1);

   assign ureq.start    = start_acc;
   assign ureq.heff     = heff;
   assign ureq.height   = h_raised;
   assign ureq.neg_rows = above_top ? NEG_W'(neg_diff >> 9) : '0;

   twcs_seq_unit u_seq (
      .clock (clock),
      .reset (reset),
      .ureq  (ureq),
      .ures  (ures)
   );

   assign next_row  = row_ff + ROW_W'(1);
   assign tick_last = !in_span(next_row, span_end_ff);
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, step_ff};
   assign texel_row = clamp_texel(acc_ff[ACC_W-1:16], heff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= TEX_SIZE_W'(64);
         height_ff      <= TEX_SIZE_W'(64);
         span_active_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TEX_WIDTH:  width_ff  <= csr_wdata;
               CSR_TEX_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (start_acc) begin
            column_ff      <= in_column;
            texture_ff     <= in_side ? (in_dir_y ? TEX_SOUTH : TEX_NORTH)
                                      : (in_dir_x ? TEX_EAST : TEX_WEST);
            texel_col_ff   <= clamp_texel({7'd0, col_prod[FRAC_W+TEX_SIZE_W-1:FRAC_W]}, weff);
            row_ff         <= top_row;
            span_end_ff    <= span_end_in;
            span_active_ff <= in_span(top_row, span_end_in);
         end
         if (ures.done) begin
            step_ff <= ures.step;
            acc_ff  <= ures.product;
         end
         if (tick_acc && span_active_ff) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= {7'd0, texel_row, texel_col_ff, texture_ff,
                             row_ff[8:0], column_ff};
            out_last_ff  <= tick_last;
            acc_ff       <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            row_ff       <= next_row;
            if (tick_last) begin
               span_active_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // no input taken while the shared unit runs
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ures.busy |-> !req_tready)
      else $error("input accepted while the sequencer is busy");

   // the final row of a span ends it
   a_last_ends_span: assert property (@(posedge clock) disable iff (reset)
      (tick_acc && span_active_ff && tick_last) |=> !span_active_ff)
      else $error("span still active after its last pixel");

   // an active span never sits below the screen
   a_row_on_screen: assert property (@(posedge clock) disable iff (reset)
      span_active_ff |-> ({1'b0, row_ff} < (ROW_W+1)'(SCREEN_HEIGHT)))
      else $error("active span row off screen");

   // a new pixel word only follows an accepted tick
   a_word_from_tick: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff)) |-> $past(tick_acc && span_active_ff))
      else $error("pixel word without a tick");

endmodule

// File: rtl/twcs_seq_unit.sv
// twcs_seq_unit: one shared add/subtract unit under a small sequencer
// first the row step by restoring division, then the clipped-rows offset by shift-add
// depends on twcs_pkg
module twcs_seq_unit import twcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ureq_type ureq,
   output ures_type ures
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_MUL  = 2'd2;

   logic [1:0]          phase_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [QUO_W-1:0]    dvd_ff;
   logic [HEIGHT_W-1:0] dvs_ff;
   logic [HEIGHT_W-1:0] rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [NEG_W-1:0]    neg_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic                sat_ff;

   logic [HEIGHT_W:0]   rem_shift;
   logic [ACC_W-1:0]    step_sat;
   logic [SUM_W-1:0]    op_a;
   logic [SUM_W-1:0]    op_b;
   logic                op_sub;
   logic [SUM_W-1:0]    res;
   logic                sub_ok;
   logic                mul_ovf;

   assign rem_shift = {rem_ff, dvd_ff[QUO_W-1]};
   assign step_sat  = quo_ff[QUO_W-1] ? ACC_MAX : quo_ff[ACC_W-1:0];

   // the one shared adder
   always_comb begin
      if (phase_ff == PH_MUL) begin
         op_sub = 1'b0;
         op_a   = {1'b0, acc_ff, 1'b0};
         op_b   = neg_ff[NEG_W-1] ? {2'b00, step_sat} : '0;
      end else begin
         op_sub = 1'b1;
         op_a   = {{(SUM_W-HEIGHT_W-1){1'b0}}, rem_shift};
         op_b   = {{(SUM_W-HEIGHT_W){1'b0}}, dvs_ff};
      end
      res = op_sub ? (op_a - op_b) : (op_a + op_b);
   end

   assign sub_ok  = !res[SUM_W-1];
   assign mul_ovf = sat_ff || (res[SUM_W-1:ACC_W] != 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (ureq.start) begin
                  dvd_ff   <= {ureq.heff, {HEIGHT_W{1'b0}}};
                  dvs_ff   <= ureq.height;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  neg_ff   <= ureq.neg_rows;
                  cnt_ff   <= CNT_W'(DIV_STEPS - 1);
                  phase_ff <= PH_DIV;
               end
            end
            PH_DIV: begin
               rem_ff <= sub_ok ? res[HEIGHT_W-1:0] : rem_shift[HEIGHT_W-1:0];
               quo_ff <= {quo_ff[QUO_W-2:0], sub_ok};
               dvd_ff <= {dvd_ff[QUO_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  cnt_ff   <= CNT_W'(MUL_STEPS - 1);
                  acc_ff   <= '0;
                  sat_ff   <= 1'b0;
                  phase_ff <= PH_MUL;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            PH_MUL: begin
               // msb first: acc = 2*acc + bit*step, saturation is sticky
               acc_ff <= res[ACC_W-1:0];
               sat_ff <= mul_ovf;
               neg_ff <= {neg_ff[NEG_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  phase_ff <= PH_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign ures.busy    = (phase_ff != PH_IDLE);
   assign ures.done    = (phase_ff == PH_MUL) && (cnt_ff == '0);
   assign ures.step    = step_sat;
   assign ures.product = mul_ovf ? ACC_MAX : res[ACC_W-1:0];

endmodule

// File: test/tb_textured_wall_column_span.sv
// tb_textured_wall_column_span: self-checking bench for the wall column span block
// predicts every pixel word in a scoreboard class; needs twcs_pkg and textured_wall_column_span
`timescale 1ns / 100ps

module tb_textured_wall_column_span;
   import twcs_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_TICKS    = 40;

   typedef struct packed {
      logic [9:0] screen_x;
      logic [8:0] screen_y;
      logic [1:0] texture_id;
      logic [9:0] texel_col;
      logic [9:0] texel_row;
      logic       last;
   } pixel_type;

   class column_span_scoreboard;
      logic [10:0]     tex_width = 11'd64;
      logic [10:0]     tex_height = 11'd64;
      bit              span_live;
      logic [9:0]      col_latched;
      logic [9:0]      row_now;
      longint unsigned span_end_q8;
      longint unsigned row_step;
      longint unsigned row_acc;
      logic [1:0]      wall_texture;
      logic [9:0]      wall_texel_col;
      pixel_type       pixels[$];
      int              errors;

      function longint unsigned effective_size(logic [10:0] v);
         if (v == 0) return 1;
         if (v > TEXTURE_MAX) return TEXTURE_MAX;
         return v;
      endfunction

      function logic [9:0] clamp_coord(longint unsigned v, longint unsigned size);
         if (v > size - 1) v = size - 1;
         if (v > 1023) v = 1023;
         return v[9:0];
      endfunction

      function bit row_visible(longint unsigned row);
         return row < SCREEN_HEIGHT && (row << 8) < span_end_q8;
      endfunction

      function longint unsigned saturate(longint unsigned v);
         return (v > ACC_MAX) ? longint'(ACC_MAX) : v;
      endfunction

      function void set_size(logic idx, logic [10:0] v);
         if (idx == CSR_TEX_WIDTH) tex_width = v;
         else tex_height = v;
      endfunction

      function int pending();
         return pixels.size();
      endfunction

      function void note_failure(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // one accepted input word: a start sets up the column, a tick yields a pixel
      function void note_word(logic op, logic [71:0] d);
         longint unsigned h, w_eff, h_eff, frac, top, neg, center, nxt;
         pixel_type px;
         h_eff = effective_size(tex_height);
         center = HALF_HEIGHT;
         if (op == OP_START) begin
            h = d[68:45];
            if (h == 0) h = 1;
            w_eff = effective_size(tex_width);
            col_latched = d[9:0];
            if (d[42] == 1'b0) begin
               wall_texture = d[43] ? TEX_EAST : TEX_WEST;
               frac = d[41:26];
            end else begin
               wall_texture = d[44] ? TEX_SOUTH : TEX_NORTH;
               frac = d[25:10];
            end
            wall_texel_col = clamp_coord((frac * w_eff) >> 16, w_eff);
            row_step = saturate((h_eff << 24) / h);
            row_acc = 0;
            if (center * 512 >= h) begin
               top = (center * 512 - h) >> 9;
            end else begin
               // rows above the screen top are skipped, the texture row jumps ahead
               neg = (h - center * 512) >> 9;
               row_acc = saturate(neg * row_step);
               top = 0;
            end
            span_end_q8 = center * 256 + ((h + 1) >> 1);
            row_now = top[9:0];
            span_live = row_visible(top);
         end else if (span_live) begin
            nxt = longint'(row_now) + 1;
            px.screen_x = col_latched;
            px.screen_y = row_now[8:0];
            px.texture_id = wall_texture;
            px.texel_col = wall_texel_col;
            px.texel_row = clamp_coord(row_acc >> 16, h_eff);
            px.last = !row_visible(nxt);
            pixels.push_back(px);
            row_acc = saturate(row_acc + row_step);
            row_now = nxt[9:0];
            if (px.last) span_live = 0;
         end
      endfunction

      function void check_pixel(logic [47:0] d, logic tlast);
         pixel_type got, want;
         got.screen_x = d[9:0];
         got.screen_y = d[18:10];
         got.texture_id = d[20:19];
         got.texel_col = d[30:21];
         got.texel_row = d[40:31];
         got.last = tlast;
         if (pixels.size() == 0) begin
            note_failure($sformatf("unexpected pixel x=%0d y=%0d tex=%0d col=%0d row=%0d last=%0b",
               got.screen_x, got.screen_y, got.texture_id, got.texel_col, got.texel_row,
               got.last));
            return;
         end
         want = pixels.pop_front();
         if (got.screen_x != want.screen_x || got.screen_y != want.screen_y ||
             got.texture_id != want.texture_id || got.texel_col != want.texel_col ||
             got.texel_row != want.texel_row || got.last != want.last)
            note_failure($sformatf(
               "pixel: expected x=%0d y=%0d tex=%0d col=%0d row=%0d last=%0b, got x=%0d y=%0d tex=%0d col=%0d row=%0d last=%0b",
               want.screen_x, want.screen_y, want.texture_id, want.texel_col, want.texel_row,
               want.last, got.screen_x, got.screen_y, got.texture_id, got.texel_col,
               got.texel_row, got.last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [10:0] csr_wdata;

   column_span_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_left;
   int counted_items;

   textured_wall_column_span u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [71:0] start_word(logic [9:0] col, logic [15:0] fx,
                                              logic [15:0] fy, logic side, logic dxp,
                                              logic dyp, logic [23:0] h);
      return {3'b000, h, dyp, dxp, side, fy, fx, col};
   endfunction

   // ticks carry junk in the unused fields
   function automatic logic [71:0] tick_noise();
      return {3'b000, 24'($urandom), 16'($urandom), 16'($urandom), 13'($urandom)};
   endfunction

   task automatic put_word(input logic op, input logic [71:0] d);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      if (op == OP_START || sb.span_live) counted_items++;
      sb.note_word(op, d);
   endtask

   task automatic run_column(input logic [71:0] setup, input int max_ticks);
      int n;
      put_word(OP_START, setup);
      n = 0;
      while (sb.span_live && n < max_ticks) begin
         put_word(OP_TICK, tick_noise());
         n++;
      end
   endtask

   task automatic random_column();
      int pick;
      int limit;
      logic [23:0] h;
      pick = $urandom_range(0, 99);
      if (pick < 75) h = 24'($urandom_range(0, 16 * 256));
      else if (pick < 90) h = 24'($urandom_range(120000, 126000));
      else h = 24'($urandom);
      // tall walls are cut short by the next start
      limit = (pick < 60) ? 1000 : $urandom_range(0, 12);
      run_column(start_word(10'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                            1'($urandom), 1'($urandom), h), limit);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 2)) put_word(OP_TICK, tick_noise());
   endtask

   // let every pixel drain and a pending column setup finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [10:0] w, input logic [10:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_TEX_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.set_size(CSR_TEX_WIDTH, w);
      csr_index <= CSR_TEX_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.set_size(CSR_TEX_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   task automatic sink_pixels();
      forever begin
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) > recv_stall_pct);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
      end
   endtask

   task automatic watch_progress();
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet = 0;
         else quiet++;
      end
      $display("textured_wall_column_span: mismatch");
      $finish;
   endtask

   initial begin
      logic [10:0] width_set [8];
      logic [10:0] height_set [8];
      int phase_base;
      width_set  = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd37, 11'd64, 11'd1000, 11'd513};
      height_set = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd700, 11'd17, 11'd64, 11'd5};
      sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold_left  = 0;
      counted_items  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_START;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_TEX_WIDTH;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         sink_pixels();
         watch_progress();
      join_none

      // directed columns with the reset texture sizes
      put_word(OP_TICK, tick_noise());
      run_column(start_word(10'd0, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 24'd0), 1000);
      put_word(OP_TICK, tick_noise());
      run_column(start_word(10'd1023, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 24'hFFFFFF), 3);
      run_column(start_word(10'd639, 16'hFFFF, 16'h1234, 1'b1, 1'b0, 1'b1, 24'd768), 1000);
      run_column(start_word(10'd320, 16'h8000, 16'h0001, 1'b1, 1'b1, 1'b0, 24'd122880), 2);
      run_column(start_word(10'd1, 16'h0001, 16'h0001, 1'b0, 1'b1, 1'b1, 24'd122881), 2);
      run_column(start_word(10'd512, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd123392), 3);

      for (int p = 0; p < 8; p++) begin
         settle();
         if (p >= 6) write_sizes(11'($urandom), 11'($urandom_range(1, 1100)));
         else write_sizes(width_set[p], height_set[p]);
         send_idle_pct  = (p % 4 == 1) ? 67 : (p % 4 == 3) ? 20 : 0;
         recv_stall_pct = (p % 4 == 2) ? 67 : (p % 4 == 3) ? 20 : 0;
         if (p == 2) begin
            // sink holds off while a full-screen clipped column keeps ticking in
            rsp_hold_left = HOLD_CYCLES;
            run_column(start_word(10'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b0,
                                  1'b1, 24'd200000), HOLD_TICKS);
         end
         phase_base = counted_items;
         while (counted_items - phase_base < PHASE_ITEMS) random_column();
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("textured_wall_column_span: match");
      end else begin
         $display("textured_wall_column_span: mismatch");
      end
      $finish;
   end

endmodule
